// File: design/avcspl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcspl_pkg
// Shared types and constants of the Annex-B start code locator.
// ----------------------------------------------------------------------------
package avcspl_pkg;

	localparam int unsigned MAX_FRAME_BYTES    = 1048576;
	localparam int unsigned WINDOW_BYTES       = 4;
	localparam int unsigned POS_W              = $clog2(MAX_FRAME_BYTES + 1);
	localparam int unsigned OFF_W              = 20;
	localparam int unsigned TOTAL_W            = 4;
	localparam int unsigned SIZE_W             = 3;

	localparam logic [TOTAL_W-1:0] PATTERN_TOTAL_MIN = TOTAL_W'(9);
	localparam logic [TOTAL_W-1:0] PATTERN_TOTAL_MAX = TOTAL_W'(12);
	localparam logic [OFF_W-1:0]   SPS_MIN_SPAN      = OFF_W'(4);

	localparam logic [31:0] CODE_LONG  = 32'h0000_0001;
	localparam logic [23:0] CODE_SHORT = 24'h00_0001;
	localparam logic [SIZE_W-1:0] SIZE_LONG  = SIZE_W'(4);
	localparam logic [SIZE_W-1:0] SIZE_SHORT = SIZE_W'(3);

	typedef enum logic [1:0] {
		PH_NONE,
		PH_SPS,
		PH_PPS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic             parse_ok;
		logic [OFF_W-1:0] sps_offset;
		logic [OFF_W-1:0] sps_length;
		logic [OFF_W-1:0] pps_offset;
		logic [OFF_W-1:0] pps_length;
		logic [OFF_W-1:0] header_size;
	} out_t;

	typedef struct packed {
		logic               too_long;
		phase_t             phase;
		logic [OFF_W-1:0]   sps_begin;
		logic [OFF_W-1:0]   sps_finish;
		logic [OFF_W-1:0]   pps_begin;
		logic [OFF_W-1:0]   pps_finish;
		logic [TOTAL_W-1:0] pattern_total;
	} snap_t;

endpackage

// File: design/avcspl_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcspl_scan
// Byte window scanner: tests one position per beat for a 4-byte or 3-byte
// start code and tracks SPS/PPS bounds; gives the frame state on its last beat.
// ----------------------------------------------------------------------------
module avcspl_scan import avcspl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  accept,
	input  in_t   item,
	output snap_t snap
);

	logic [31:0]        window_q,   window_d;
	logic [POS_W-1:0]   pos_q,      pos_d;
	logic               too_long_q, too_long_d;
	logic [1:0]         skip_q,     skip_d;
	phase_t             phase_q,    phase_d;
	logic [OFF_W-1:0]   sps_b_q,    sps_b_d;
	logic [OFF_W-1:0]   sps_f_q,    sps_f_d;
	logic [OFF_W-1:0]   pps_b_q,    pps_b_d;
	logic [OFF_W-1:0]   pps_f_q,    pps_f_d;
	logic [TOTAL_W-1:0] total_q,    total_d;

	logic [OFF_W-1:0]  at;
	logic [SIZE_W-1:0] size;
	logic              hit;
	logic [OFF_W-1:0]  after_code;
	logic [OFF_W-1:0]  before_code;

	assign at          = pos_q[OFF_W-1:0] - OFF_W'(WINDOW_BYTES);
	assign after_code  = at + OFF_W'(size);
	assign before_code = at - OFF_W'(1);

	always_comb begin
		hit  = 1'b1;
		size = SIZE_LONG;
		if (window_q == CODE_LONG) begin
			size = SIZE_LONG;
		end else if (window_q[31:8] == CODE_SHORT) begin
			size = SIZE_SHORT;
		end else begin
			hit = 1'b0;
		end
	end

	// next state
	always_comb begin
		window_d   = window_q;
		pos_d      = pos_q;
		too_long_d = too_long_q;
		skip_d     = skip_q;
		phase_d    = phase_q;
		sps_b_d    = sps_b_q;
		sps_f_d    = sps_f_q;
		pps_b_d    = pps_b_q;
		pps_f_d    = pps_f_q;
		total_d    = total_q;
		if (pos_q >= POS_W'(MAX_FRAME_BYTES)) begin
			too_long_d = 1'b1;
		end else begin
			if (pos_q >= POS_W'(WINDOW_BYTES) && phase_q != PH_DONE) begin
				if (skip_q != 2'd0) begin
					skip_d = skip_q - 2'd1;
				end else if (hit) begin
					total_d = total_q + TOTAL_W'(size);
					case (phase_q)
						PH_NONE: begin
							sps_b_d = after_code;
							phase_d = PH_SPS;
							skip_d  = 2'(size - SIZE_W'(1));
						end
						PH_SPS: begin
							sps_f_d = before_code;
							pps_b_d = after_code;
							phase_d = PH_PPS;
							skip_d  = 2'(size - SIZE_W'(1));
						end
						default: begin
							pps_f_d = before_code;
							phase_d = PH_DONE;
							skip_d  = 2'd0;
						end
					endcase
				end
			end
			window_d = {window_q[23:0], item.data_byte};
			pos_d    = pos_q + POS_W'(1);
		end
	end

	// frame state as it stands after this beat
	always_comb begin
		snap.too_long      = too_long_d;
		snap.phase         = phase_d;
		snap.sps_begin     = sps_b_d;
		snap.sps_finish    = sps_f_d;
		snap.pps_begin     = pps_b_d;
		snap.pps_finish    = pps_f_d;
		snap.pattern_total = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= '0;
			pos_q      <= '0;
			too_long_q <= 1'b0;
			skip_q     <= '0;
			phase_q    <= PH_NONE;
			sps_b_q    <= '0;
			sps_f_q    <= '0;
			pps_b_q    <= '0;
			pps_f_q    <= '0;
			total_q    <= '0;
		end else if (accept) begin
			if (item.frame_end) begin
				window_q   <= '0;
				pos_q      <= '0;
				too_long_q <= 1'b0;
				skip_q     <= '0;
				phase_q    <= PH_NONE;
				sps_b_q    <= '0;
				sps_f_q    <= '0;
				pps_b_q    <= '0;
				pps_f_q    <= '0;
				total_q    <= '0;
			end else begin
				window_q   <= window_d;
				pos_q      <= pos_d;
				too_long_q <= too_long_d;
				skip_q     <= skip_d;
				phase_q    <= phase_d;
				sps_b_q    <= sps_b_d;
				sps_f_q    <= sps_f_d;
				pps_b_q    <= pps_b_d;
				pps_f_q    <= pps_f_d;
				total_q    <= total_d;
			end
		end
	end

endmodule

// File: design/avcspl_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avcspl_check
// Frame checks and result fields from the captured end-of-frame state.
// ----------------------------------------------------------------------------
module avcspl_check import avcspl_pkg::*; (
	input  snap_t snap,
	output out_t  result
);

	logic             ok;
	logic [OFF_W:0]   sps_limit;
	logic [OFF_W-1:0] sps_len;
	logic [OFF_W-1:0] pps_len;

	assign sps_limit = {1'b0, snap.sps_begin} + {1'b0, SPS_MIN_SPAN};
	assign sps_len   = snap.sps_finish - snap.sps_begin + OFF_W'(1);
	assign pps_len   = snap.pps_finish - snap.pps_begin + OFF_W'(1);

	assign ok = !snap.too_long
		&& snap.phase == PH_DONE
		&& {1'b0, snap.sps_finish} >= sps_limit
		&& snap.pps_begin > snap.sps_finish
		&& snap.pps_finish > snap.pps_begin
		&& snap.pattern_total >= PATTERN_TOTAL_MIN
		&& snap.pattern_total <= PATTERN_TOTAL_MAX;

	always_comb begin
		result = '0;
		if (ok) begin
			result.parse_ok    = 1'b1;
			result.sps_offset  = snap.sps_begin;
			result.sps_length  = sps_len;
			result.pps_offset  = snap.pps_begin;
			result.pps_length  = pps_len;
			result.header_size = sps_len + pps_len + OFF_W'(snap.pattern_total);
		end
	end

endmodule

// File: design/avc_sps_pps_start_code_locator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avc_sps_pps_start_code_locator
// Finds the first three Annex-B start codes of a key frame and reports the
// SPS and PPS bounds and the header size on the frame's last byte.
//
//   channel  signals                     beat
//   in       in_valid/in_ready/in_data   one frame byte plus last-byte flag
//   out      out_valid/out_ready/out_data one result per frame
//
// one byte per cycle while in_ready is high; the scanner state updates in
// the cycle a beat is taken; after the last byte the result passes the
// capture stage, then the check stage into the output register
// reset clears all scan state; the scan also restarts after every last byte
// a stalled output holds the capture stage; input stalls only when both are full
// ----------------------------------------------------------------------------
module avc_sps_pps_start_code_locator import avcspl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic  in_fire;
	logic  adv_s2;
	snap_t snap;
	snap_t snap_s1;
	logic  snap_valid_s1;
	out_t  result;
	out_t  out_q;
	logic  out_valid_q;

	assign adv_s2   = !out_valid_q || out_ready;
	assign in_ready = !snap_valid_s1 || adv_s2;
	assign in_fire  = in_valid && in_ready;

	avcspl_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (in_fire),
		.item   (in_data),
		.snap   (snap)
	);

	avcspl_check u_check (
		.snap   (snap_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire && in_data.frame_end) begin
				snap_valid_s1 <= 1'b1;
			end else if (adv_s2) begin
				snap_valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				out_valid_q <= snap_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_data.frame_end) begin
			snap_s1 <= snap;
		end
		if (adv_s2 && snap_valid_s1) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_last_captured: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.frame_end |=> snap_valid_s1)
		else $error("last beat not captured");

	a_pps_after_sps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.parse_ok |-> out_data.pps_offset > out_data.sps_offset)
		else $error("pps offset not after sps offset");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.parse_ok |->
			out_data.sps_offset == '0 && out_data.sps_length == '0 &&
			out_data.pps_offset == '0 && out_data.pps_length == '0 &&
			out_data.header_size == '0)
		else $error("failed result carries nonzero fields");

endmodule
